// ----- sv/pcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcr_pkg
// shared constants, register codes and the divider control type of the pwm capture unit
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int PER_BITS  = 28;
  localparam int NUM_W     = PER_BITS + 1;
  localparam int PER_IDX_W = $clog2(PER_BITS);
  localparam int TICK_BITS = 24;
  localparam int CFG_W     = 28;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 2'd3;

  localparam logic [TICK_BITS-1:0] RST_TICK_STEP  = 24'd50000;
  localparam logic [PER_BITS-1:0]  RST_PERIOD     = 28'd1000000;
  localparam logic [PER_BITS-1:0]  RST_MAX_PERIOD = 28'd200000000;

  typedef struct packed {
    logic load;
    logic step;
  } pcr_div_ctl_t;

endpackage

// ----- sv/pcr_rdiv.sv -----
// ----------------------------------------------------------------------------
// pcr_rdiv
// restoring divider, one quotient bit per step, remainder and numerator
// shift register shared by the phase wrap and the duty computation
// ----------------------------------------------------------------------------
module pcr_rdiv
  import pcr_pkg::*;
(
  input  logic                clk,
  input  pcr_div_ctl_t        ctl,
  input  logic [PER_BITS-1:0] rem_init,
  input  logic [NUM_W-1:0]    num_init,
  input  logic [PER_BITS-1:0] dvsr,
  output logic [PER_BITS-1:0] rem,
  output logic [NUM_W-1:0]    num
);

  logic [PER_BITS-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [PER_BITS:0]   trial;
  logic [PER_BITS:0]   diff;
  logic                ge;

  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, dvsr};
    ge    = trial >= {1'b0, dvsr};
    rem_nxt = rem_r;
    num_nxt = num_r;
    if (ctl.load) begin
      rem_nxt = rem_init;
      num_nxt = num_init;
    end else if (ctl.step) begin
      rem_nxt = ge ? diff[PER_BITS-1:0] : trial[PER_BITS-1:0];
      num_nxt = {num_r[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign rem = rem_r;
  assign num = num_r;

endmodule

// ----- sv/pwm_capture_regenerate_unit.sv -----
// ----------------------------------------------------------------------------
// pwm_capture_regenerate_unit
// measures period and duty of an incoming pwm from edge words and
// regenerates the output level on tick words
// ----------------------------------------------------------------------------
// edge word: bit-serial time subtract in S_SUB, then S_EVAL; a falling edge with a duty
//   divide adds the S_DIV steps and S_DFIN before the result is issued from S_DONE
// tick word: S_TICK runs the 29-step phase wrap divider with the duty shift-add, then S_TEVAL
// one word at a time; in_ready rises in the same cycle as the result lands, S_DONE waits on out_ready
// synchronous active-low reset restores register and state defaults
// ----------------------------------------------------------------------------
module pwm_capture_regenerate_unit
  import pcr_pkg::*;
#(
  parameter int TIME_BITS      = 48,
  parameter int DUTY_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic                      in_edge_level,
  input  logic [TIME_BITS-1:0]      in_time_ns,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_pwm_out,
  output logic                      out_level_changed,
  output logic [PER_BITS-1:0]       out_measured_period_ns,
  output logic [DUTY_FRAC_BITS:0]   out_duty_q16,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  localparam int DUTY_W = DUTY_FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(TIME_BITS + 1);
  localparam logic [DUTY_W-1:0] DUTY_ONE     = {1'b1, {DUTY_FRAC_BITS{1'b0}}};
  localparam logic [DUTY_W-1:0] RST_MIN_DUTY = DUTY_W'((1 << DUTY_FRAC_BITS) / 100);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUB   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DFIN  = 3'd4;
  localparam logic [2:0] S_TICK  = 3'd5;
  localparam logic [2:0] S_TEVAL = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // configuration
  logic [TICK_BITS-1:0] tick_step_r;
  logic [PER_BITS-1:0]  def_period_r;
  logic [PER_BITS-1:0]  max_period_r;
  logic [DUTY_W-1:0]    min_duty_r;

  // architectural state
  logic [TIME_BITS-1:0] rise_r, rise_nxt;
  logic [PER_BITS-1:0]  period_r, period_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  logic [PER_BITS-1:0]  phase_r, phase_nxt;
  logic                 lvl_r, lvl_nxt;

  // sequencer
  logic [2:0]           st_r, st_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // serial datapath
  logic [TIME_BITS-1:0] time_sh_r, time_sh_nxt;
  logic [PER_BITS-1:0]  diff_sh_r, diff_sh_nxt;
  logic                 borrow_r, borrow_nxt;
  logic                 nz_r, nz_nxt;
  logic                 rise_nz_r, rise_nz_nxt;
  logic                 lt_max_r, lt_max_nxt;
  logic                 lt_per_r, lt_per_nxt;
  logic                 edge_lvl_r, edge_lvl_nxt;
  logic                 changed_r, changed_nxt;
  logic [PER_BITS-1:0]  per_eff_r, per_eff_nxt;
  logic [NUM_W-1:0]     acc_r, acc_nxt;
  logic [DUTY_W-1:0]    dsh_r, dsh_nxt;

  // result word
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pwm_r, out_pwm_nxt;
  logic                 out_chg_r, out_chg_nxt;
  logic [PER_BITS-1:0]  out_per_r, out_per_nxt;
  logic [DUTY_W-1:0]    out_duty_r, out_duty_nxt;

  pcr_div_ctl_t         div_ctl;
  logic [PER_BITS-1:0]  div_rem_init;
  logic [NUM_W-1:0]     div_num_init;
  logic [PER_BITS-1:0]  div_rem;
  logic [NUM_W-1:0]     div_num;

  logic                 in_acc;
  logic                 a_bit, b_bit, d_bit;
  logic                 in_rng;
  logic [PER_IDX_W-1:0] bidx;
  logic                 m_bit, p_bit;
  logic                 per_bad;
  logic [PER_BITS-1:0]  per_sel;
  logic [NUM_W-1:0]     acc_add;
  logic                 go_div;
  logic                 out_free;

  pcr_rdiv u_rdiv (
    .clk      (clk),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .dvsr     (per_eff_r),
    .rem      (div_rem),
    .num      (div_num)
  );

  assign in_ready = (st_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    per_bad = (period_r == '0) || (period_r > max_period_r);
    per_sel = per_bad ? def_period_r : period_r;
    a_bit   = time_sh_r[0];
    b_bit   = rise_r[0];
    d_bit   = a_bit ^ b_bit ^ borrow_r;
    in_rng  = cnt_r < CNT_W'(PER_BITS);
    bidx    = cnt_r[PER_IDX_W-1:0];
    m_bit   = in_rng && max_period_r[bidx];
    p_bit   = in_rng && period_r[bidx];
    acc_add = acc_r + (dsh_r[0] ? {1'b0, per_eff_r} : '0);
    go_div  = !edge_lvl_r && rise_nz_r && (period_r != '0) && lt_per_r;
  end

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    rise_nxt     = rise_r;
    period_nxt   = period_r;
    duty_nxt     = duty_r;
    phase_nxt    = phase_r;
    lvl_nxt      = lvl_r;
    time_sh_nxt  = time_sh_r;
    diff_sh_nxt  = diff_sh_r;
    borrow_nxt   = borrow_r;
    nz_nxt       = nz_r;
    rise_nz_nxt  = rise_nz_r;
    lt_max_nxt   = lt_max_r;
    lt_per_nxt   = lt_per_r;
    edge_lvl_nxt = edge_lvl_r;
    changed_nxt  = changed_r;
    per_eff_nxt  = per_eff_r;
    acc_nxt      = acc_r;
    dsh_nxt      = dsh_r;
    div_ctl      = '0;
    div_rem_init = diff_sh_r;
    div_num_init = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pwm_nxt  = out_pwm_r;
    out_chg_nxt  = out_chg_r;
    out_per_nxt  = out_per_r;
    out_duty_nxt = out_duty_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if (in_operation) begin
            // tick: wrap phase + step by the effective period
            per_eff_nxt  = (per_sel == '0) ? PER_BITS'(1) : per_sel;
            div_ctl.load = 1'b1;
            div_rem_init = '0;
            div_num_init = NUM_W'(phase_r) + NUM_W'(tick_step_r);
            acc_nxt      = '0;
            dsh_nxt      = duty_r;
            st_nxt       = S_TICK;
          end else begin
            time_sh_nxt  = in_time_ns;
            edge_lvl_nxt = in_edge_level;
            borrow_nxt   = 1'b0;
            nz_nxt       = 1'b0;
            rise_nz_nxt  = 1'b0;
            lt_max_nxt   = 1'b0;
            lt_per_nxt   = 1'b0;
            changed_nxt  = 1'b0;
            st_nxt       = S_SUB;
          end
        end
      end
      S_SUB: begin
        // lsb-first subtract with running compares against max and period
        time_sh_nxt = {a_bit, time_sh_r[TIME_BITS-1:1]};
        rise_nxt    = {b_bit, rise_r[TIME_BITS-1:1]};
        borrow_nxt  = (!a_bit && b_bit) || (!(a_bit ^ b_bit) && borrow_r);
        nz_nxt      = nz_r || d_bit;
        rise_nz_nxt = rise_nz_r || b_bit;
        lt_max_nxt  = (d_bit ^ m_bit) ? m_bit : lt_max_r;
        lt_per_nxt  = (d_bit ^ p_bit) ? p_bit : lt_per_r;
        if (in_rng) begin
          diff_sh_nxt = {d_bit, diff_sh_r[PER_BITS-1:1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TIME_BITS - 1)) begin
          st_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cnt_nxt = '0;
        st_nxt  = S_DONE;
        if (edge_lvl_r) begin
          if (rise_nz_r && nz_r && lt_max_r) begin
            period_nxt = diff_sh_r;
          end
          rise_nxt = time_sh_r;
        end else if (go_div) begin
          per_eff_nxt  = period_r;
          div_ctl.load = 1'b1;
          st_nxt       = S_DIV;
        end else if (rise_nz_r && (period_r != '0)) begin
          duty_nxt = DUTY_ONE;
        end
      end
      S_DIV: begin
        div_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DUTY_FRAC_BITS - 1)) begin
          st_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        duty_nxt = {1'b0, div_num[DUTY_FRAC_BITS-1:0]};
        st_nxt   = S_DONE;
      end
      S_TICK: begin
        div_ctl.step = 1'b1;
        // shift-add high time, lsb of duty first
        if (cnt_r < CNT_W'(DUTY_FRAC_BITS)) begin
          acc_nxt = {1'b0, acc_add[NUM_W-1:1]};
          dsh_nxt = {1'b0, dsh_r[DUTY_W-1:1]};
        end else if (cnt_r == CNT_W'(DUTY_FRAC_BITS)) begin
          acc_nxt = acc_add;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          st_nxt = S_TEVAL;
        end
      end
      S_TEVAL: begin
        phase_nxt   = div_rem;
        lvl_nxt     = (duty_r > min_duty_r) && ({1'b0, div_rem} < acc_r);
        changed_nxt = lvl_nxt != lvl_r;
        st_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pwm_nxt   = lvl_r;
          out_chg_nxt   = changed_r;
          out_per_nxt   = period_r;
          out_duty_nxt  = duty_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      tick_step_r  <= RST_TICK_STEP;
      def_period_r <= RST_PERIOD;
      max_period_r <= RST_MAX_PERIOD;
      min_duty_r   <= RST_MIN_DUTY;
      rise_r       <= '0;
      period_r     <= RST_PERIOD;
      duty_r       <= '0;
      phase_r      <= '0;
      lvl_r        <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rise_r      <= rise_nxt;
      period_r    <= period_nxt;
      duty_r      <= duty_nxt;
      phase_r     <= phase_nxt;
      lvl_r       <= lvl_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICK_STEP:  tick_step_r  <= cfg_wdata[TICK_BITS-1:0];
          REG_DEF_PERIOD: def_period_r <= cfg_wdata[PER_BITS-1:0];
          REG_MAX_PERIOD: max_period_r <= cfg_wdata[PER_BITS-1:0];
          REG_MIN_DUTY:   min_duty_r   <= cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    time_sh_r  <= time_sh_nxt;
    diff_sh_r  <= diff_sh_nxt;
    borrow_r   <= borrow_nxt;
    nz_r       <= nz_nxt;
    rise_nz_r  <= rise_nz_nxt;
    lt_max_r   <= lt_max_nxt;
    lt_per_r   <= lt_per_nxt;
    edge_lvl_r <= edge_lvl_nxt;
    changed_r  <= changed_nxt;
    per_eff_r  <= per_eff_nxt;
    acc_r      <= acc_nxt;
    dsh_r      <= dsh_nxt;
    out_pwm_r  <= out_pwm_nxt;
    out_chg_r  <= out_chg_nxt;
    out_per_r  <= out_per_nxt;
    out_duty_r <= out_duty_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_pwm_out            = out_pwm_r;
  assign out_level_changed      = out_chg_r;
  assign out_measured_period_ns = out_per_r;
  assign out_duty_q16           = out_duty_r;

  // duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= DUTY_ONE)
    else $error("duty above full scale");

  // measured period is never zero
  a_period_nz: assert property (@(posedge clk) disable iff (!rst_n)
    period_r != '0)
    else $error("stored period is zero");

  // wrapped phase stays below the effective period
  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TEVAL) |=> (phase_r < per_eff_r))
    else $error("phase not wrapped");

  // output high only with duty above the minimum
  a_lvl_min: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TEVAL) |=> (!lvl_r || (duty_r > min_duty_r)))
    else $error("output high with duty at or below minimum");

endmodule
